/* sv/usrl_pkg.sv */
// shared types and constants for the ultrasonic range safety lock
package usrl_pkg;

  // parameter defaults
  localparam int TRIG_LOW_TICKS_DEF  = 2;
  localparam int TRIG_HIGH_TICKS_DEF = 10;
  localparam int COUNT_BITS_DEF      = 20;

  // register field widths
  localparam int THR_W  = 10;
  localparam int TMO_W  = 16;
  localparam int GAP_W  = 20;
  localparam int DIST_W = 15;
  localparam int EVT_W  = 2;
  localparam int WID_W  = 16;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET = 10'd20;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd15000;
  localparam logic [GAP_W-1:0] GAP_RESET = 20'd100000;

  // apb map
  localparam int ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_THR = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_TMO = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_GAP = 4'h8;

  // echo width to centimetres: 58 ticks per cm
  localparam logic [5:0] CM_TICKS = 6'd58;
  // floor(x / 29) as (x * DIV29_MUL) >> DIV29_SHIFT, exact for x below 2^19
  localparam int DIV29_SHIFT = 24;
  localparam logic [19:0] DIV29_MUL = 20'd578525;

  // lock events
  localparam logic [EVT_W-1:0] EVT_NONE     = 2'd0;
  localparam logic [EVT_W-1:0] EVT_ENGAGED  = 2'd1;
  localparam logic [EVT_W-1:0] EVT_RELEASED = 2'd2;

  typedef enum logic [4:0] {
    PH_PAUSE = 5'b00001,
    PH_TLOW  = 5'b00010,
    PH_THIGH = 5'b00100,
    PH_RISE  = 5'b01000,
    PH_FALL  = 5'b10000
  } phase_t;

endpackage

/* sv/ultrasonic_range_safety_lock.sv */
// ultrasonic rangefinder controller with distance based safety lock
//
// usage
//   s_axis: one beat per microsecond tick, tdata[0] echo pin level,
//   tdata[1] sensor enable. each accepted beat gives exactly one result
//   beat on m_axis with the trigger level to drive for that tick, the
//   done strobe, the latest distance (q4 centimetres) with its valid flag,
//   the lock state and a lock engaged/released event.
//   apb: threshold_cm at 0x0, echo_timeout_ticks at 0x4,
//   measure_gap_ticks at 0x8; write only while the stream is idle.
// timing and throughput
//   the sequencer state and the result are updated at the edge that takes
//   the input beat, so the result is valid in the next cycle. one beat per
//   cycle is sustained while m_axis_tready stays high; the longest path
//   is the 19 by 20 bit reciprocal multiply that divides 8 x width by 29.
// reset
//   synchronous rst puts the sequencer in the pause phase with a zero
//   count, releases the lock, clears the reading and reloads the register
//   defaults (20 cm, 15000 ticks, 100000 ticks). no result beat is pending.
// stall
//   the result register holds its beat while m_axis_tready is low and
//   s_axis_tready drops, so no tick is lost; a new beat is taken as it drains
module ultrasonic_range_safety_lock #(
  parameter int TRIG_LOW_TICKS  = usrl_pkg::TRIG_LOW_TICKS_DEF,
  parameter int TRIG_HIGH_TICKS = usrl_pkg::TRIG_HIGH_TICKS_DEF,
  parameter int COUNT_BITS      = usrl_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // apb configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [usrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input ticks: [0] echo_level, [1] sensor_enable
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  // results: [0] trigger_level, [1] measurement_done, [2] distance_valid,
  // [17:3] distance_q4, [18] lock_engaged, [20:19] lock_event
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata
);
  import usrl_pkg::*;

  localparam int CW = COUNT_BITS + 1;
  localparam int WW = (CW > GAP_W) ? CW : GAP_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [THR_W-1:0] threshold_cm;
  logic [TMO_W-1:0] echo_timeout_ticks;
  logic [GAP_W-1:0] measure_gap_ticks;

  // sequencer state
  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic                  lock_flag, lock_flag_next;
  logic [DIST_W-1:0]     last_distance, last_distance_next;
  logic                  last_valid, last_valid_next;

  // result register
  logic              out_trig, out_done;
  logic [EVT_W-1:0]  out_event;

  logic accept;
  logic echo, enable;

  // arithmetic helpers
  logic [WW-1:0]          next_w;
  logic [WW-1:0]          gap_len;
  logic                   gap_end, tlow_end, thigh_end;
  logic [COUNT_BITS-1:0]  count_inc;
  logic                   inc_over;
  logic                   one_over;
  logic [WID_W-1:0]       width;
  logic [WID_W+2:0]       width_x8;
  logic [WID_W+22:0]      div_prod;
  logic [DIST_W-1:0]      dist_calc;
  logic [WID_W-1:0]       thr_ticks;
  logic                   lock_calc;
  logic                   trig_next, done_next;
  logic [EVT_W-1:0]       event_next;
  logic                   finish, finish_ok;

  assign pready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign echo   = s_axis_tdata[0];
  assign enable = s_axis_tdata[1];

  // apb write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_cm       <= THR_RESET;
      echo_timeout_ticks <= TMO_RESET;
      measure_gap_ticks  <= GAP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        ADDR_THR: threshold_cm       <= pwdata[THR_W-1:0];
        ADDR_TMO: echo_timeout_ticks <= pwdata[TMO_W-1:0];
        ADDR_GAP: measure_gap_ticks  <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_THR: prdata = {{(32-THR_W){1'b0}}, threshold_cm};
      ADDR_TMO: prdata = {{(32-TMO_W){1'b0}}, echo_timeout_ticks};
      ADDR_GAP: prdata = {{(32-GAP_W){1'b0}}, measure_gap_ticks};
      default:  prdata = 32'd0;
    endcase
  end

  // phase length checks; the gap is cut to what the counter can hold
  assign next_w    = WW'(tick_count) + WW'(1);
  assign gap_len   = (WW'(measure_gap_ticks) > WW'(CNT_MAX)) ? WW'(CNT_MAX)
                                                             : WW'(measure_gap_ticks);
  assign gap_end   = next_w >= gap_len;
  assign tlow_end  = next_w >= WW'(TRIG_LOW_TICKS);
  assign thigh_end = next_w >= WW'(TRIG_HIGH_TICKS);

  // echo wait counting, wraps at the counter width
  assign count_inc = tick_count + COUNT_BITS'(1);
  assign inc_over  = count_inc > COUNT_BITS'(echo_timeout_ticks);
  assign one_over  = echo_timeout_ticks == '0;

  // a finished width never passes the 16 bit timeout
  assign width     = tick_count[WID_W-1:0];
  assign width_x8  = {width, 3'b000};
  assign div_prod  = width_x8 * DIV29_MUL;
  assign dist_calc = div_prod[DIV29_SHIFT +: DIST_W];
  assign thr_ticks = WID_W'(threshold_cm) * WID_W'(CM_TICKS);
  assign lock_calc = (width != '0) && (width < thr_ticks);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    lock_flag_next     = lock_flag;
    last_distance_next = last_distance;
    last_valid_next    = last_valid;
    trig_next          = 1'b0;
    done_next          = 1'b0;
    finish             = 1'b0;
    finish_ok          = 1'b0;

    if (!enable) begin
      phase_next         = PH_PAUSE;
      tick_count_next    = '0;
      last_valid_next    = 1'b0;
      last_distance_next = '0;
      lock_flag_next     = 1'b0;
    end else begin
      case (phase)
        PH_PAUSE: begin
          if (gap_end) begin
            phase_next      = PH_TLOW;
            tick_count_next = '0;
          end else begin
            tick_count_next = next_w[COUNT_BITS-1:0];
          end
        end
        PH_TLOW: begin
          if (tlow_end) begin
            phase_next      = PH_THIGH;
            tick_count_next = '0;
          end else begin
            tick_count_next = next_w[COUNT_BITS-1:0];
          end
        end
        PH_THIGH: begin
          if (thigh_end) begin
            phase_next      = PH_RISE;
            tick_count_next = '0;
          end else begin
            trig_next       = 1'b1;
            tick_count_next = next_w[COUNT_BITS-1:0];
          end
        end
        PH_RISE: begin
          if (echo) begin
            phase_next      = PH_FALL;
            tick_count_next = COUNT_BITS'(1);
            finish          = one_over;
          end else begin
            tick_count_next = count_inc;
            finish          = inc_over;
          end
        end
        PH_FALL: begin
          if (echo) begin
            tick_count_next = count_inc;
            finish          = inc_over;
          end else begin
            finish    = 1'b1;
            finish_ok = 1'b1;
          end
        end
        default: begin
          phase_next      = PH_PAUSE;
          tick_count_next = '0;
        end
      endcase

      if (finish) begin
        done_next       = 1'b1;
        phase_next      = PH_PAUSE;
        tick_count_next = '0;
        if (finish_ok) begin
          last_valid_next    = 1'b1;
          last_distance_next = dist_calc;
          lock_flag_next     = lock_calc;
        end else begin
          last_valid_next    = 1'b0;
          last_distance_next = '0;
          lock_flag_next     = 1'b0;
        end
      end
    end

    if (lock_flag_next == lock_flag) begin
      event_next = EVT_NONE;
    end else if (lock_flag_next) begin
      event_next = EVT_ENGAGED;
    end else begin
      event_next = EVT_RELEASED;
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PAUSE;
      tick_count    <= '0;
      lock_flag     <= 1'b0;
      last_distance <= '0;
      last_valid    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      lock_flag     <= lock_flag_next;
      last_distance <= last_distance_next;
      last_valid    <= last_valid_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_trig  <= trig_next;
      out_done  <= done_next;
      out_event <= event_next;
    end
  end

  // the reading and lock fields come straight from the updated state
  assign m_axis_tdata = {3'b000, out_event, lock_flag, last_distance,
                         last_valid, out_done, out_trig};

endmodule

/* sim/tb.sv */
// self-checking testbench for the ultrasonic range safety lock
`timescale 1ns / 1ps

module tb;
  import usrl_pkg::*;

  // one result beat, first field in the lowest bits, zero pad on top
  typedef struct packed {
    logic [2:0]        pad;
    logic [EVT_W-1:0]  evt;
    logic              lock;
    logic [DIST_W-1:0] dist_q4;
    logic              valid;
    logic              done;
    logic              trig;
  } tick_report_t;

  // tracks the sequencer and the lock, and holds the reports still due
  class range_lock_checker;
    logic [THR_W-1:0]          thr_cm;
    logic [TMO_W-1:0]          tmo_ticks;
    logic [GAP_W-1:0]          gap_ticks;
    phase_t                    phase;
    logic [COUNT_BITS_DEF-1:0] tick_cnt;
    logic                      lock_on;
    logic [DIST_W-1:0]         last_dist;
    logic                      last_ok;
    tick_report_t              due_results[$];
    int                        errors;

    function new();
      thr_cm    = THR_RESET;
      tmo_ticks = TMO_RESET;
      gap_ticks = GAP_RESET;
      phase     = PH_PAUSE;
      tick_cnt  = '0;
      lock_on   = 1'b0;
      last_dist = '0;
      last_ok   = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
      case (addr)
        ADDR_THR: thr_cm = data[THR_W-1:0];
        ADDR_TMO: tmo_ticks = data[TMO_W-1:0];
        ADDR_GAP: gap_ticks = data[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    // steps a timed phase; a length of zero ends after one tick
    function bit phase_over(int unsigned len);
      int unsigned nxt;
      nxt = tick_cnt + 1;
      if (nxt >= len) begin
        tick_cnt = '0;
        return 1'b1;
      end
      tick_cnt = nxt[COUNT_BITS_DEF-1:0];
      return 1'b0;
    endfunction

    function void take_tick(bit echo, bit en);
      tick_report_t r;
      logic         was_locked;
      bit           finish;
      bit           ok;
      int unsigned  width;
      r          = '0;
      was_locked = lock_on;
      finish     = 1'b0;
      ok         = 1'b0;
      width      = 0;
      if (!en) begin
        phase     = PH_PAUSE;
        tick_cnt  = '0;
        last_ok   = 1'b0;
        last_dist = '0;
        lock_on   = 1'b0;
      end else begin
        case (phase)
          PH_PAUSE: if (phase_over(gap_ticks)) phase = PH_TLOW;
          PH_TLOW: if (phase_over(TRIG_LOW_TICKS_DEF)) phase = PH_THIGH;
          PH_THIGH: begin
            r.trig = 1'b1;
            if (phase_over(TRIG_HIGH_TICKS_DEF)) begin
              phase  = PH_RISE;
              r.trig = 1'b0;
            end
          end
          PH_RISE: begin
            // the rising tick is the first tick of the width
            if (echo) begin
              phase    = PH_FALL;
              tick_cnt = COUNT_BITS_DEF'(1);
            end else begin
              tick_cnt = tick_cnt + 1'b1;
            end
            finish = (tick_cnt > tmo_ticks);
          end
          PH_FALL: begin
            if (echo) begin
              tick_cnt = tick_cnt + 1'b1;
              finish   = (tick_cnt > tmo_ticks);
            end else begin
              finish = 1'b1;
              ok     = 1'b1;
              width  = tick_cnt;
            end
          end
          default: begin
            phase    = PH_PAUSE;
            tick_cnt = '0;
          end
        endcase
        if (finish) begin
          r.done   = 1'b1;
          phase    = PH_PAUSE;
          tick_cnt = '0;
          last_ok  = ok;
          if (ok) begin
            last_dist = DIST_W'((width * 16) / CM_TICKS);
            lock_on   = (width > 0) && (width < thr_cm * CM_TICKS);
          end else begin
            last_dist = '0;
            lock_on   = 1'b0;
          end
        end
      end
      r.valid   = last_ok;
      r.dist_q4 = last_dist;
      r.lock    = lock_on;
      if (lock_on == was_locked) r.evt = EVT_NONE;
      else r.evt = lock_on ? EVT_ENGAGED : EVT_RELEASED;
      due_results.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(logic [23:0] data);
      tick_report_t got;
      tick_report_t want;
      got = data;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat %h expected none", $time, data);
        return;
      end
      want = due_results.pop_front();
      cmp_field("trigger_level", want.trig, got.trig);
      cmp_field("measurement_done", want.done, got.done);
      cmp_field("distance_valid", want.valid, got.valid);
      cmp_field("distance_q4", want.dist_q4, got.dist_q4);
      cmp_field("lock_engaged", want.lock, got.lock);
      cmp_field("lock_event", want.evt, got.evt);
      cmp_field("pad bits", want.pad, got.pad);
    endfunction
  endclass

  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // [0] echo_level, [1] sensor_enable, [7:2] zero
  logic [7:0]        s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready;
  // [0] trigger_level, [1] measurement_done, [2] distance_valid,
  // [17:3] distance_q4, [18] lock_engaged, [20:19] lock_event, [23:21] zero
  logic [23:0]       m_tdata;

  // receiver: random stalls, plus one long hold-off counted in its own process
  logic rdy_rand = 1'b0;
  logic holding = 1'b0;
  bit   hold_go = 1'b0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  bit   noisy = 1'b0;
  int   items_sent = 0;

  range_lock_checker sb = new();

  assign m_tready = rdy_rand & ~holding;

  ultrasonic_range_safety_lock u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rdy_rand <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // long stall so the output register fills and the input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // every accepted result beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_result(m_tdata);
  end

  // offers one tick and returns at the edge that takes it; the prediction
  // is made here so the stimulus can look at the tracked phase
  task automatic send_tick(bit echo, bit en);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, en, echo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_tick(echo, en);
    items_sent++;
  endtask

  // sender pauses until every predicted beat has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access; the register takes the value at the access edge
  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic set_regs(int unsigned thr, int unsigned tmo, int unsigned gap);
    apb_write(ADDR_THR, thr);
    apb_write(ADDR_TMO, tmo);
    apb_write(ADDR_GAP, gap);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // occasional dropped enable breaks a sequence part way through
  function automatic bit pick_enable();
    return !(noisy && $urandom_range(0, 39) == 0);
  endfunction

  // low ticks before the echo rises: mostly short, sometimes on the timeout
  function automatic int pick_low(int unsigned tmo);
    if ($urandom_range(0, 7) == 0) return tmo + $urandom_range(0, 1);
    return $urandom_range(0, 4);
  endfunction

  // echo width: around the timeout, around the lock distance, or anywhere
  function automatic int pick_width(int unsigned thr, int unsigned tmo);
    int w;
    case ($urandom_range(0, 3))
      0: w = tmo + $urandom_range(0, 1);
      1: begin
        w = thr * 58 - 1 + $urandom_range(0, 2);
        if (w > tmo + 1) w = tmo + 1;
      end
      default: w = $urandom_range(1, tmo + 1);
    endcase
    return (w < 1) ? 1 : w;
  endfunction

  // one measurement: ride out pause and trigger, then shape the echo
  task automatic run_cycle(int low, int width);
    int guard;
    guard = 0;
    while (sb.phase != PH_RISE && guard < 80) begin
      send_tick(1'($urandom_range(0, 1)), pick_enable());
      guard++;
    end
    repeat (low) send_tick(1'b0, pick_enable());
    repeat (width) send_tick(1'b1, pick_enable());
    send_tick(1'b0, 1'b1);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_stage(int n, int unsigned thr, int unsigned tmo, int unsigned gap,
                           int src_pct, int snk_pct, bit with_hold);
    int stop_at;
    drain();
    set_regs(thr, tmo, gap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (with_hold) hold_go = 1'b1;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) noise_burst();
      else run_cycle(pick_low(tmo), pick_width(thr, tmo));
    end
  endtask

  initial begin
    int src_pcts[4];
    int snk_pcts[4];
    int k;
    src_pcts = '{0, 46, 0, 19};
    snk_pcts = '{0, 0, 46, 19};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: disabled ticks, then the start of a long pause
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);

    // zero gap, one tick wide echo engages the lock, disabling releases it
    drain();
    set_regs(1, 2, 0);
    run_cycle(0, 1);
    send_tick(1'b1, 1'b0);

    noisy = 1'b1;
    run_stage(80, 1, 70, 0, 0, 0, 1'b0);
    run_stage(80, 1023, 40, 3, 46, 0, 1'b0);
    // zero timeout always fails, zero threshold never locks
    run_stage(80, 0, 0, 1, 0, 46, 1'b0);

    // largest timeout and gap: the block just sits in its pause
    drain();
    set_regs(1023, 65535, 1048575);
    src_idle_pct  = 19;
    snk_stall_pct = 19;
    repeat (20) send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 5) != 0);

    run_stage(60, 2, 150, 5, 19, 19, 1'b1);
    for (k = 0; k < 4; k++) begin
      run_stage(30, $urandom_range(0, 3), $urandom_range(0, 160), $urandom_range(0, 8),
                src_pcts[k], snk_pcts[k], 1'b0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
